[hdl/acu_pkg.sv]
// Shared types and constants of the alarm clock set-and-alarm unit.
package acu_pkg;

   localparam int ALARM_W     = 23;
   localparam int ALARM_COUNT = 3;
   localparam int CSR_IDX_W   = 2;

   // Event kinds of one request beat
   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_ENCODER = 2'd1;
   localparam logic [1:0] KIND_MODE    = 2'd2;
   localparam logic [1:0] KIND_BUTTON  = 2'd3;

   // Set-menu positions
   localparam logic [2:0] MENU_OFF    = 3'd0;
   localparam logic [2:0] MENU_DAY    = 3'd1;
   localparam logic [2:0] MENU_HOUR   = 3'd2;
   localparam logic [2:0] MENU_MINUTE = 3'd3;
   localparam logic [2:0] MENU_SECOND = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_ZERO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_ONE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_TWO  = 2'd2;

   localparam logic [ALARM_W-1:0] ALARM_RESET = 23'h004800;

   // Action bits
   localparam int ACT_BEEP_BIT   = 0;
   localparam int ACT_RINGER_BIT = 1;

   typedef logic [ALARM_W-1:0] alarm_type;
   typedef alarm_type [ALARM_COUNT-1:0] alarm_set_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] enc_pins;
   } req_type;

   typedef struct packed {
      logic [2:0] day_of_week;
      logic [4:0] hour_bcd;
      logic [6:0] minute_bcd;
      logic [6:0] second_bcd;
      logic       pm_flag;
      logic [2:0] menu_field;
      logic [2:0] alarm_actions;
      logic       ringer_on;
      logic       speaker_gate;
      logic       display_changed;
   } rsp_type;

   // Time of day that the alarms are matched against
   typedef struct packed {
      logic [2:0] day;
      logic [4:0] hour;
      logic [6:0] minute;
      logic       pm;
   } clock_type;

endpackage

[hdl/acu_alarm_match.sv]
// Compare of the three alarm registers against the time of day.
module acu_alarm_match (
   input  acu_pkg::clock_type     now,
   input  acu_pkg::alarm_set_type alarms,
   output logic [2:0]             hit_actions
);
   import acu_pkg::*;

   always_comb begin
      hit_actions = 3'b000;
      for (int i = 0; i < ALARM_COUNT; i++) begin
         if ((alarms[i][2:0] != 3'b000) &&
             (now.day != 3'd7) && alarms[i][3 + now.day] &&
             (alarms[i][22] == now.pm) &&
             (alarms[i][14:10] == now.hour) &&
             (alarms[i][21:15] == now.minute)) begin
            hit_actions = hit_actions | alarms[i][2:0];
         end
      end
   end

endmodule

[hdl/acu_core.sv]
// Clock, menu, encoder and alarm state with its per-event update logic.
module acu_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  acu_pkg::req_type       item,
   input  acu_pkg::alarm_set_type alarms,
   output acu_pkg::rsp_type       result
);
   import acu_pkg::*;

   logic [6:0] second_ff, second_in;
   logic [6:0] minute_ff, minute_in;
   logic [4:0] hour_ff, hour_in;
   logic       pm_ff, pm_in;
   logic [2:0] day_ff, day_in;
   logic [2:0] menu_ff, menu_in;
   logic [7:0] hist_ff, hist_in;
   logic [2:0] act_ff, act_in;
   logic       ringer_ff, ringer_in;
   logic       speaker_ff, speaker_in;
   logic       changed;

   // tick path
   logic [6:0] sec_tk, min_tk;
   logic [4:0] hr_tk;
   logic       pm_tk;
   logic [2:0] day_tk;
   clock_type  now_tk;
   logic [2:0] hits;
   logic [2:0] act_chk, act_tk;
   logic       ringer_tk;
   logic [7:0] hist_sh;

   function automatic logic [6:0] bcd_inc7(input logic [6:0] v);
      if (v[3:0] >= 4'h9) return {v[6:4] + 3'd1, 4'h0};
      return v + 7'd1;
   endfunction

   function automatic logic [4:0] bcd_inc5(input logic [4:0] v);
      if (v[3:0] >= 4'h9) return {v[4] + 1'b1, 4'h0};
      return v + 5'd1;
   endfunction

   // Advance the time of day by one second
   always_comb begin
      sec_tk = second_ff;
      min_tk = minute_ff;
      hr_tk  = hour_ff;
      pm_tk  = pm_ff;
      day_tk = day_ff;
      if (second_ff < 7'h59) begin
         sec_tk = bcd_inc7(second_ff);
      end else begin
         sec_tk = 7'h00;
         if (minute_ff < 7'h59) begin
            min_tk = bcd_inc7(minute_ff);
         end else begin
            min_tk = 7'h00;
            if (hour_ff == 5'h12) begin
               hr_tk = 5'h01;
            end else if (hour_ff == 5'h11) begin
               hr_tk = 5'h12;
               pm_tk = ~pm_ff;
               if (pm_ff) day_tk = (day_ff >= 3'd6) ? 3'd0 : day_ff + 3'd1;
            end else begin
               hr_tk = bcd_inc5(hour_ff);
            end
         end
      end
      now_tk = '{day: day_tk, hour: hr_tk, minute: min_tk, pm: pm_tk};
   end

   acu_alarm_match u_match (
      .now         (now_tk),
      .alarms      (alarms),
      .hit_actions (hits)
   );

   always_comb begin
      act_chk = (act_ff & 3'b101) | hits;
      if (sec_tk == 7'h00) begin
         act_tk    = act_chk;
         ringer_tk = act_chk[ACT_RINGER_BIT];
      end else begin
         act_tk    = act_ff;
         ringer_tk = ringer_ff;
      end
   end

   always_comb begin
      second_in  = second_ff;
      minute_in  = minute_ff;
      hour_in    = hour_ff;
      pm_in      = pm_ff;
      day_in     = day_ff;
      menu_in    = menu_ff;
      hist_in    = hist_ff;
      act_in     = act_ff;
      ringer_in  = ringer_ff;
      speaker_in = speaker_ff;
      changed    = 1'b0;
      hist_sh    = {hist_ff[5:0], item.enc_pins};
      case (item.kind)
         KIND_TICK: begin
            second_in  = sec_tk;
            minute_in  = min_tk;
            hour_in    = hr_tk;
            pm_in      = pm_tk;
            day_in     = day_tk;
            act_in     = act_tk;
            ringer_in  = ringer_tk;
            speaker_in = speaker_ff ^ act_tk[ACT_BEEP_BIT];
            changed    = 1'b1;
         end
         KIND_ENCODER: begin
            hist_in = hist_sh;
            if (hist_sh[3:0] == 4'hB) begin
               case (menu_ff)
                  MENU_DAY: begin
                     day_in  = (day_ff == 3'd6) ? 3'd0 : day_ff + 3'd1;
                     changed = 1'b1;
                  end
                  MENU_HOUR: begin
                     if (hour_ff == 5'h12) begin
                        hour_in = 5'h01;
                        pm_in   = ~pm_ff;
                     end else if (hour_ff == 5'h09) begin
                        hour_in = 5'h10;
                     end else begin
                        hour_in = hour_ff + 5'd1;
                     end
                     changed = 1'b1;
                  end
                  MENU_MINUTE: begin
                     minute_in = (minute_ff == 7'h59) ? 7'h00 : bcd_inc7(minute_ff);
                     changed   = 1'b1;
                  end
                  default: ;
               endcase
            end else if (hist_sh[3:0] == 4'h7) begin
               case (menu_ff)
                  MENU_DAY: begin
                     day_in  = (day_ff == 3'd0) ? 3'd6 : day_ff - 3'd1;
                     changed = 1'b1;
                  end
                  MENU_HOUR: begin
                     if (hour_ff == 5'h01) begin
                        hour_in = 5'h12;
                        pm_in   = ~pm_ff;
                     end else if (hour_ff == 5'h10) begin
                        hour_in = 5'h09;
                     end else begin
                        hour_in = hour_ff - 5'd1;
                     end
                     changed = 1'b1;
                  end
                  MENU_MINUTE: begin
                     if (minute_ff == 7'h00) minute_in = 7'h59;
                     else if (minute_ff[3:0] == 4'h0) minute_in = {minute_ff[6:4] - 3'd1, 4'h9};
                     else minute_in = minute_ff - 7'd1;
                     changed = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         KIND_MODE: begin
            menu_in = (menu_ff < MENU_SECOND) ? menu_ff + 3'd1 : MENU_OFF;
            changed = 1'b1;
         end
         KIND_BUTTON: begin
            if (menu_ff == MENU_OFF) begin
               act_in     = 3'b000;
               ringer_in  = 1'b0;
               speaker_in = 1'b0;
               changed    = 1'b1;
            end else if (menu_ff == MENU_SECOND) begin
               second_in = 7'h00;
               changed   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      result.day_of_week     = day_in;
      result.hour_bcd        = hour_in;
      result.minute_bcd      = minute_in;
      result.second_bcd      = second_in;
      result.pm_flag         = pm_in;
      result.menu_field      = menu_in;
      result.alarm_actions   = act_in;
      result.ringer_on       = ringer_in;
      result.speaker_gate    = speaker_in;
      result.display_changed = changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff  <= 7'h00;
         minute_ff  <= 7'h00;
         hour_ff    <= 5'h12;
         pm_ff      <= 1'b0;
         day_ff     <= 3'd0;
         menu_ff    <= MENU_OFF;
         hist_ff    <= 8'h00;
         act_ff     <= 3'b000;
         ringer_ff  <= 1'b0;
         speaker_ff <= 1'b0;
      end else if (step_en) begin
         second_ff  <= second_in;
         minute_ff  <= minute_in;
         hour_ff    <= hour_in;
         pm_ff      <= pm_in;
         day_ff     <= day_in;
         menu_ff    <= menu_in;
         hist_ff    <= hist_in;
         act_ff     <= act_in;
         ringer_ff  <= ringer_in;
         speaker_ff <= speaker_in;
      end
   end

`ifndef SYNTHESIS
   a_ringer_follows_action: assert property (@(posedge clock) disable iff (reset)
      ringer_ff == act_ff[ACT_RINGER_BIT])
      else $error("ringer drive out of step with ringer action");
   a_menu_range: assert property (@(posedge clock) disable iff (reset)
      menu_ff <= MENU_SECOND)
      else $error("menu position beyond second");
   a_hour_nonzero: assert property (@(posedge clock) disable iff (reset)
      hour_ff != 5'h00)
      else $error("hour register reached zero");
`endif

endmodule

[hdl/alarm_clock_set_and_alarm_unit_top.sv]
// Top level of the alarm clock set-and-alarm unit: beat staging and alarm registers.
//
// Each request beat is one event: a second tick, an encoder pin sample, a mode
// press or an encoder-button press. The unit takes one beat per clock cycle
// for as long as the response side keeps up; a beat lands in the input
// register on acceptance and, once it advances, the update pass changes the
// clock state and loads the response register. The throughput figure of one
// beat per cycle is set by the single update pass between the input register
// and the response register, which reads and writes the clock state in the
// same cycle. Both registers stall in place while the response register is
// full and rsp_ready is low, and the input register frees up in the same
// cycle the response register drains, so no bubble appears.
// Exactly one response beat comes out per request beat, carrying the time,
// menu position and alarm flags after the event, plus a display-changed flag.
// The three alarm registers are written through the csr_ port (index 0 to 2,
// other indexes are dropped) and should be written only while no beat is in
// flight. Alarm matching happens on a tick whose seconds wrap to zero.
module alarm_clock_set_and_alarm_unit_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  acu_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output acu_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [acu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [acu_pkg::ALARM_W-1:0]       csr_wdata
);
   import acu_pkg::*;

   logic          in_valid_ff, in_valid_in;
   req_type       in_data_ff, in_data_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   alarm_set_type alarm_ff, alarm_in;
   logic          advance;
   rsp_type       step_result;

   // Advance a staged beat when the response register is empty or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   acu_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .alarms  (alarm_ff),
      .result  (step_result)
   );

   always_comb begin
      // Input register: load on acceptance, drop once advanced
      in_data_in  = (req_valid && req_ready) ? req_data : in_data_ff;
      in_valid_in = req_valid || (in_valid_ff && !advance);
      if (!req_ready) in_valid_in = in_valid_ff;

      // Response register: load on advance, hold while stalled
      rsp_data_in  = advance ? step_result : rsp_data_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

      // Alarm registers
      alarm_in = alarm_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ALARM_ZERO: alarm_in[0] = csr_wdata;
            CSR_ALARM_ONE:  alarm_in[1] = csr_wdata;
            CSR_ALARM_TWO:  alarm_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         alarm_ff     <= {ALARM_COUNT{ALARM_RESET}};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         alarm_ff     <= alarm_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced beat did not reach the response register");
   a_tick_redraws: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.kind == KIND_TICK) |=> rsp_data_ff.display_changed)
      else $error("tick response without display change");
   a_mode_redraws: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.kind == KIND_MODE) |=> rsp_data_ff.display_changed)
      else $error("mode response without display change");
   a_rsp_ringer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.ringer_on == rsp_data_ff.alarm_actions[ACT_RINGER_BIT])
      else $error("response ringer out of step with ringer action");
`endif

endmodule

[test/acu_result_checker.sv]
// Checker of the alarm clock unit: predicts each response beat and compares it.
module acu_result_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  acu_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  acu_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [acu_pkg::CSR_IDX_W-1:0] csr_index,
   input  acu_pkg::alarm_type            csr_wdata,
   output int                            fail_count,
   output int                            outstanding,
   output acu_pkg::clock_type            clock_now,
   output logic [2:0]                    menu_now
);
   import acu_pkg::*;

   localparam logic [3:0] ENC_STEP_UP   = 4'hB;
   localparam logic [3:0] ENC_STEP_DOWN = 4'h7;

   alarm_type   alarm_regs [ALARM_COUNT];
   logic [6:0]  sec_q, min_q;
   logic [4:0]  hour_q;
   logic        pm_q;
   logic [2:0]  day_q, menu_q;
   logic [7:0]  enc_hist;
   logic [2:0]  actions_q;
   logic        ringer_q, speaker_q;
   rsp_type     pending_displays [$];
   int          errors = 0;

   function automatic logic [7:0] bcd_up(logic [7:0] v);
      if (v[3:0] >= 4'd9) return {v[7:4] + 4'd1, 4'd0};
      return v + 8'd1;
   endfunction

   // Apply one event to the shadow clock and return the display it leaves.
   function automatic rsp_type next_display(req_type r);
      logic [7:0] t;
      logic [7:0] mask;
      alarm_type  a;
      logic       changed;
      rsp_type    d;
      changed = 1'b0;
      case (r.kind)
         KIND_TICK: begin
            changed = 1'b1;
            if (sec_q >= 7'h59) begin
               sec_q = 7'h00;
               if (min_q >= 7'h59) begin
                  min_q = 7'h00;
                  if (hour_q == 5'h12) begin
                     hour_q = 5'h01;
                  end else if (hour_q == 5'h11) begin
                     hour_q = 5'h12;
                     pm_q = ~pm_q;
                     if (!pm_q) day_q = (day_q >= 3'd6) ? 3'd0 : day_q + 3'd1;
                  end else begin
                     t = bcd_up({3'b000, hour_q});
                     hour_q = t[4:0];
                  end
               end else begin
                  t = bcd_up({1'b0, min_q});
                  min_q = t[6:0];
               end
            end else begin
               t = bcd_up({1'b0, sec_q});
               sec_q = t[6:0];
            end
            // minute rollover: rematch alarms, time out the ringer
            if (sec_q == 7'h00) begin
               actions_q[ACT_RINGER_BIT] = 1'b0;
               for (int i = 0; i < ALARM_COUNT; i++) begin
                  a = alarm_regs[i];
                  mask = {1'b0, a[9:3]};
                  if (a[2:0] != 3'd0 && mask[day_q] && a[22] == pm_q &&
                      a[14:10] == hour_q && a[21:15] == min_q) begin
                     actions_q = actions_q | a[2:0];
                     if (a[ACT_RINGER_BIT]) ringer_q = 1'b1;
                  end
               end
               if (ringer_q && !actions_q[ACT_RINGER_BIT]) ringer_q = 1'b0;
            end
            if (actions_q[ACT_BEEP_BIT]) speaker_q = ~speaker_q;
         end
         KIND_ENCODER: begin
            enc_hist = {enc_hist[5:0], r.enc_pins};
            if (enc_hist[3:0] == ENC_STEP_UP || enc_hist[3:0] == ENC_STEP_DOWN) begin
               case (menu_q)
                  MENU_DAY: begin
                     if (enc_hist[3:0] == ENC_STEP_UP)
                        day_q = (day_q == 3'd6) ? 3'd0 : day_q + 3'd1;
                     else
                        day_q = (day_q == 3'd0) ? 3'd6 : day_q - 3'd1;
                     changed = 1'b1;
                  end
                  MENU_HOUR: begin
                     if (enc_hist[3:0] == ENC_STEP_UP) begin
                        if (hour_q == 5'h12) begin
                           hour_q = 5'h01;
                           pm_q = ~pm_q;
                        end else if (hour_q == 5'h09) begin
                           hour_q = 5'h10;
                        end else begin
                           hour_q = hour_q + 5'd1;
                        end
                     end else begin
                        if (hour_q == 5'h01) begin
                           hour_q = 5'h12;
                           pm_q = ~pm_q;
                        end else if (hour_q == 5'h10) begin
                           hour_q = 5'h09;
                        end else begin
                           hour_q = hour_q - 5'd1;
                        end
                     end
                     changed = 1'b1;
                  end
                  MENU_MINUTE: begin
                     if (enc_hist[3:0] == ENC_STEP_UP) begin
                        t = bcd_up({1'b0, min_q});
                        min_q = (min_q == 7'h59) ? 7'h00 : t[6:0];
                     end else if (min_q == 7'h00) begin
                        min_q = 7'h59;
                     end else if (min_q[3:0] == 4'd0) begin
                        min_q = min_q - 7'h10 + 7'h09;
                     end else begin
                        min_q = min_q - 7'd1;
                     end
                     changed = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         KIND_MODE: begin
            menu_q = (menu_q < MENU_SECOND) ? menu_q + 3'd1 : MENU_OFF;
            changed = 1'b1;
         end
         default: begin
            if (menu_q == MENU_OFF) begin
               actions_q = 3'd0;
               ringer_q = 1'b0;
               speaker_q = 1'b0;
               changed = 1'b1;
            end else if (menu_q == MENU_SECOND) begin
               sec_q = 7'h00;
               changed = 1'b1;
            end
         end
      endcase
      d.day_of_week     = day_q;
      d.hour_bcd        = hour_q;
      d.minute_bcd      = min_q;
      d.second_bcd      = sec_q;
      d.pm_flag         = pm_q;
      d.menu_field      = menu_q;
      d.alarm_actions   = actions_q;
      d.ringer_on       = ringer_q;
      d.speaker_gate    = speaker_q;
      d.display_changed = changed;
      return d;
   endfunction

   task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < ALARM_COUNT; i++) alarm_regs[i] = ALARM_RESET;
         sec_q = 7'h00;
         min_q = 7'h00;
         hour_q = 5'h12;
         pm_q = 1'b0;
         day_q = 3'd0;
         menu_q = MENU_OFF;
         enc_hist = 8'h00;
         actions_q = 3'd0;
         ringer_q = 1'b0;
         speaker_q = 1'b0;
         pending_displays.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ALARM_ZERO: alarm_regs[0] = csr_wdata;
               CSR_ALARM_ONE:  alarm_regs[1] = csr_wdata;
               CSR_ALARM_TWO:  alarm_regs[2] = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_displays.size() == 0) begin
               $error("response beat with no request waiting");
               errors++;
            end else begin
               want = pending_displays.pop_front();
               check_field("day_of_week", 8'(want.day_of_week),
                           8'(rsp_data.day_of_week));
               check_field("hour_bcd", 8'(want.hour_bcd), 8'(rsp_data.hour_bcd));
               check_field("minute_bcd", 8'(want.minute_bcd), 8'(rsp_data.minute_bcd));
               check_field("second_bcd", 8'(want.second_bcd), 8'(rsp_data.second_bcd));
               check_field("pm_flag", 8'(want.pm_flag), 8'(rsp_data.pm_flag));
               check_field("menu_field", 8'(want.menu_field), 8'(rsp_data.menu_field));
               check_field("alarm_actions", 8'(want.alarm_actions),
                           8'(rsp_data.alarm_actions));
               check_field("ringer_on", 8'(want.ringer_on), 8'(rsp_data.ringer_on));
               check_field("speaker_gate", 8'(want.speaker_gate),
                           8'(rsp_data.speaker_gate));
               check_field("display_changed", 8'(want.display_changed),
                           8'(rsp_data.display_changed));
            end
         end
         if (req_valid && req_ready) pending_displays.push_back(next_display(req_data));
      end
      outstanding <= pending_displays.size();
      fail_count  <= errors;
      clock_now   <= {day_q, hour_q, min_q, pm_q};
      menu_now    <= menu_q;
   end

endmodule

[test/alarm_clock_set_and_alarm_unit_top_tb.sv]
// Testbench top of the alarm clock unit: stimulus, idling and the verdict.
module alarm_clock_set_and_alarm_unit_top_tb;
   import acu_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   alarm_type            csr_wdata = '0;

   int                   fail_count;
   int                   outstanding;
   clock_type            clock_now;
   logic [2:0]           menu_now;

   int                   tx_idle_pct = 0;
   int                   rx_idle_pct = 0;
   int                   beats_sent = 0;

   alarm_clock_set_and_alarm_unit_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The checker watches both channels and the csr port beside the block.
   acu_result_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .clock_now   (clock_now),
      .menu_now    (menu_now)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stall the response side at random; rx_idle_pct sets how often.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #(400000 * 8);
      $display("FAILED: results differ");
      $finish;
   end

   // Offer one beat, idling first at random; return at the accepting edge.
   // Valid is left high so a following beat goes out without a bubble.
   task automatic send_beat(logic [1:0] kind, logic [1:0] pins);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: kind, enc_pins: pins};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // Drop valid and hold until every predicted response has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // One full detent of the encoder: two phase samples ending in 2'b11.
   task automatic turn_encoder(logic up);
      send_beat(KIND_ENCODER, up ? 2'd2 : 2'd1);
      send_beat(KIND_ENCODER, 2'd3);
   endtask

   // Press mode until the menu sits where asked, one press at a time.
   task automatic go_menu(logic [2:0] target);
      wait_idle();
      while (menu_now != target) begin
         send_beat(KIND_MODE, 2'd0);
         wait_idle();
      end
   endtask

   // Write all three alarm registers back to back; only call while idle.
   task automatic write_alarms(alarm_type a0, alarm_type a1, alarm_type a2);
      alarm_type words [ALARM_COUNT];
      words = '{a0, a1, a2};
      for (int i = 0; i < ALARM_COUNT; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= words[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Mostly an alarm aimed at the given time with random actions and days,
   // otherwise a fully random word.
   function automatic alarm_type pick_alarm(clock_type at);
      logic [6:0] mask;
      mask = 7'($urandom);
      if ($urandom_range(0, 3) != 0) mask[at.day] = 1'b1;
      if ($urandom_range(0, 2) == 0) return alarm_type'($urandom);
      return {at.pm, at.minute, at.hour, mask, 3'($urandom_range(0, 7))};
   endfunction

   initial begin
      clock_type at;
      logic      up;
      int        goal;

      // Hold reset, then release it once for good.
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase one of idling: sender rarely, receiver mostly.
      tx_idle_pct = 13;
      rx_idle_pct <= 70;

      // Extreme alarm words first: all ones never matches a real hour.
      write_alarms(23'h7FFFFF, 23'h000000, ALARM_RESET);

      // Directed walk: every event kind, both encoder directions in each
      // field menu, and the wrap cases of day, hour and minute.
      send_beat(KIND_TICK, 2'd0);
      send_beat(KIND_BUTTON, 2'd0);       // silence in the off menu
      send_beat(KIND_MODE, 2'd0);         // day menu
      turn_encoder(1'b1);
      turn_encoder(1'b0);
      turn_encoder(1'b0);                 // Sunday down wraps to Saturday
      turn_encoder(1'b1);                 // Saturday up wraps to Sunday
      send_beat(KIND_MODE, 2'd0);         // hour menu
      turn_encoder(1'b1);                 // 12 up to 1 flips PM
      turn_encoder(1'b0);                 // 1 down to 12 flips it back
      send_beat(KIND_BUTTON, 2'd0);       // no effect in the hour menu
      send_beat(KIND_MODE, 2'd0);         // minute menu
      turn_encoder(1'b0);                 // 00 down wraps to 59
      turn_encoder(1'b1);                 // 59 up wraps to 00
      send_beat(KIND_MODE, 2'd0);         // second menu
      send_beat(KIND_TICK, 2'd0);
      send_beat(KIND_BUTTON, 2'd0);       // clear the seconds
      send_beat(KIND_ENCODER, 2'd0);      // history shifts, nothing moves
      send_beat(KIND_MODE, 2'd0);         // back to off

      goal = beats_sent;
      for (int phase = 0; phase < 3; phase++) begin
         // Swap the idling sides, then run with no idling at all.
         if (phase == 1) begin
            tx_idle_pct = 70;
            rx_idle_pct <= 13;
         end else if (phase == 2) begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
         end
         goal += 370;
         while (beats_sent < goal) begin
            case ($urandom_range(0, 11))
               0: begin
                  // Walk the clock to 11:59 PM and tick across midnight so
                  // that PM drops and the weekday advances.
                  go_menu(MENU_HOUR);
                  while (!(clock_now.hour == 5'h11 && clock_now.pm)) begin
                     turn_encoder(1'b1);
                     wait_idle();
                  end
                  go_menu(MENU_MINUTE);
                  up = (clock_now.minute >= 7'h30);
                  while (clock_now.minute != 7'h59) begin
                     turn_encoder(up);
                     wait_idle();
                  end
                  at = clock_now;
                  at.day = (at.day >= 3'd6) ? 3'd0 : at.day + 3'd1;
                  at.hour = 5'h12;
                  at.minute = 7'h00;
                  at.pm = 1'b0;
                  write_alarms(pick_alarm(at), pick_alarm(at), pick_alarm(at));
                  go_menu(MENU_SECOND);
                  send_beat(KIND_BUTTON, 2'd0);
                  go_menu(MENU_OFF);
                  repeat ($urandom_range(60, 64)) send_beat(KIND_TICK, 2'd0);
               end
               1, 2, 3, 4: begin
                  // Aim the alarms at the current minute, step the minute
                  // back one, clear the seconds and tick up to the rollover.
                  wait_idle();
                  at = clock_now;
                  write_alarms(pick_alarm(at), pick_alarm(at), pick_alarm(at));
                  go_menu(MENU_MINUTE);
                  turn_encoder(1'b0);
                  go_menu(MENU_SECOND);
                  send_beat(KIND_BUTTON, 2'd0);
                  go_menu(MENU_OFF);
                  repeat ($urandom_range(60, 68)) begin
                     if ($urandom_range(0, 7) == 0)
                        send_beat(KIND_ENCODER, 2'($urandom_range(0, 3)));
                     send_beat(KIND_TICK, 2'd0);
                  end
                  if ($urandom_range(0, 1) == 0) send_beat(KIND_BUTTON, 2'd0);
               end
               5, 6, 7: begin
                  // Spin the encoder in a field menu with stray samples.
                  go_menu(3'($urandom_range(MENU_DAY, MENU_MINUTE)));
                  repeat ($urandom_range(5, 20)) begin
                     if ($urandom_range(0, 4) == 0)
                        send_beat(KIND_ENCODER, 2'($urandom_range(0, 3)));
                     else
                        turn_encoder(1'($urandom_range(0, 1)));
                  end
               end
               default: begin
                  // Raw noise: any kind, any pins.
                  repeat ($urandom_range(10, 30))
                     send_beat(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
               end
            endcase
         end
      end

      // Drain, let the pipeline settle, then give the verdict.
      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/acu_pkg.sv
hdl/acu_alarm_match.sv
hdl/acu_core.sv
hdl/alarm_clock_set_and_alarm_unit_top.sv
test/acu_result_checker.sv
test/alarm_clock_set_and_alarm_unit_top_tb.sv
